// ===== hw/rtl/cms_pkg.sv =====
// Shared types, codes and option-field helpers for the CoAP message serializer.
// No dependencies; imported by cms_front, cms_back, cms_checker and the core.
package cms_pkg;

  // Item kinds on the input channel
  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_UINT   = 3'd1;
  localparam logic [2:0] KIND_OPAQUE = 3'd2;
  localparam logic [2:0] KIND_MARKER = 3'd3;
  localparam logic [2:0] KIND_DATA   = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [15:0] CAP_RESET    = 16'd1024;
  localparam logic [3:0]  TKL_MAX      = 4'd8;
  localparam logic [15:0] HDR_BYTES    = 16'd4;
  localparam logic [1:0]  COAP_VERSION = 2'd1;
  localparam logic [7:0]  MARKER_BYTE  = 8'hFF;

  // Option delta/length encoding thresholds
  localparam logic [15:0] OPT_EXT1_MIN = 16'd13;
  localparam logic [15:0] OPT_EXT2_MIN = 16'd269;
  localparam logic [3:0]  OPT_NIB_EXT1 = 4'd13;
  localparam logic [3:0]  OPT_NIB_EXT2 = 4'd14;

  // Classified command handed from front to back
  typedef enum logic [2:0] {
    OP_HEADER,
    OP_UINT,
    OP_OPAQUE,
    OP_MARKER,
    OP_DATA,
    OP_STATUS
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [1:0]      status;        // OP_STATUS only
    logic [7:0]      head;          // first byte for non-option ops
    logic [3:0][7:0] tail;          // bytes after head / delta ext, [0] first
    logic [2:0]      tail_cnt;
    logic [3:0]      len_nib;
    logic [3:0]      tok_len;
    logic [15:0]     opt_num;
    logic [15:0]     value_length;
  } cmd_t;

  function automatic logic [3:0] opt_nibble(input logic [15:0] v);
    if (v < OPT_EXT1_MIN) return v[3:0];
    else if (v < OPT_EXT2_MIN) return OPT_NIB_EXT1;
    else return OPT_NIB_EXT2;
  endfunction

  function automatic logic [1:0] opt_ext_cnt(input logic [15:0] v);
    if (v >= OPT_EXT2_MIN) return 2'd2;
    else if (v >= OPT_EXT1_MIN) return 2'd1;
    else return 2'd0;
  endfunction

  // Extension bytes, [0] goes out first
  function automatic logic [1:0][7:0] opt_ext_bytes(input logic [15:0] v);
    logic [15:0] e2;
    logic [15:0] e1;
    e2 = v - OPT_EXT2_MIN;
    e1 = v - OPT_EXT1_MIN;
    if (v >= OPT_EXT2_MIN) return {e2[7:0], e2[15:8]};
    else return {8'h00, e1[7:0]};
  endfunction

endpackage

// ===== hw/rtl/cms_if.sv =====
// Channel interfaces of the CoAP message serializer: item, result and config.
// Plain valid/ready channels; no package dependency.
interface cms_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] msg_id;
  logic [1:0]  msg_type;
  logic [7:0]  code;
  logic [3:0]  tok_len;
  logic [15:0] opt_num;
  logic [31:0] option_value;
  logic [15:0] value_length;
  logic [7:0]  data_byte;

  modport source(output valid, kind, msg_id, msg_type, code, tok_len,
                 opt_num, option_value, value_length, data_byte,
                 input ready);
  modport sink(input valid, kind, msg_id, msg_type, code, tok_len,
               opt_num, option_value, value_length, data_byte,
               output ready);
endinterface

interface cms_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [1:0]  status;
  logic [15:0] message_size;

  modport source(output valid, out_byte, byte_valid, last, status, message_size,
                 input ready);
  modport sink(input valid, out_byte, byte_valid, last, status, message_size,
               output ready);
endinterface

interface cms_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== hw/rtl/coap_message_serializer_core.sv =====
// Top level of the CoAP message serializer: config register, front, queue, back.
// Depends on cms_pkg, cms_if, cms_front, cms_fifo and cms_back.
//
// Usage:
//   item   - input channel; one beat is one action on the message (header,
//            uint option, opaque option header, payload marker, data byte).
//   result - output channel; one beat per written byte in stream order, then a
//            status beat (byte_valid 0) if the item fails; a single status beat
//            when it writes nothing. The final beat of an item has last set.
//   cfg    - write channel for buffer_capacity; always ready. Write it only
//            while no item is in flight.
// An item beat reaches the result channel through the queue, the build
//   registers and the output register. The back end builds an item in S_BUILD,
//   then sends its beats through its single emit path, one byte a cycle while
//   the receiver keeps ready high; it takes no new item before its last beat.
// The front accepts into a QUEUE_DEPTH-entry queue and keeps taking items
//   while the back end works or the receiver stalls, until the queue is full;
//   with ready low the output register holds its beat and the back end waits.
// Reset: empties the queue and output register, clears write position and
//   option number, and sets buffer_capacity to 1024.
module coap_message_serializer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  cms_item_if.sink      item,
  cms_result_if.source  result,
  cms_cfg_if.sink       cfg
);
  import cms_pkg::*;

  logic [15:0] capacity;
  cmd_t        front_cmd;
  logic        front_push;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  logic [$bits(cmd_t)-1:0] q_rd_data;

  // Config: single register, accepted every cycle
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  // Front: classify input beats straight into the queue
  cms_front u_front (
    .item       (item),
    .queue_full (q_full),
    .cmd        (front_cmd),
    .cmd_push   (front_push)
  );

  // Queue decouples intake from emission
  cms_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_push),
    .wr_data (front_cmd),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: message state, byte sequencing and output register
  cms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_t'(q_rd_data)),
    .cmd_valid (!q_empty),
    .cmd_pop   (q_pop),
    .capacity  (capacity),
    .result    (result)
  );

endmodule

// ===== hw/rtl/cms_front.sv =====
// Front end: accepts input beats and classifies them into cmd_t for the queue.
// Depends on cms_pkg and cms_item_if.
module cms_front (
  cms_item_if.sink       item,
  input  logic           queue_full,
  output cms_pkg::cmd_t  cmd,
  output logic           cmd_push
);
  import cms_pkg::*;

  logic [2:0]  ucnt;
  logic [5:0]  ushift;
  logic [31:0] uval_al;

  assign item.ready = !queue_full;
  assign cmd_push   = item.valid && !queue_full;

  // minimal big-endian uint: drop leading zero bytes, left-align the rest
  always_comb begin
    ucnt = {2'b00, |item.option_value[31:24]} + {2'b00, |item.option_value[31:16]}
         + {2'b00, |item.option_value[31:8]}  + {2'b00, |item.option_value};
    ushift  = {3'd4 - ucnt, 3'b000};
    uval_al = item.option_value << ushift;
  end

  always_comb begin
    cmd              = '0;
    cmd.op           = OP_STATUS;
    cmd.status       = ST_INVALID;
    cmd.tok_len      = item.tok_len;
    cmd.opt_num      = item.opt_num;
    cmd.value_length = item.value_length;
    unique case (item.kind)
      KIND_HEADER: begin
        if (item.tok_len <= TKL_MAX) begin
          cmd.op       = OP_HEADER;
          cmd.head     = {COAP_VERSION, item.msg_type, item.tok_len};
          cmd.tail[0]  = item.code;
          cmd.tail[1]  = item.msg_id[15:8];
          cmd.tail[2]  = item.msg_id[7:0];
          cmd.tail_cnt = 3'd3;
        end
      end
      KIND_UINT: begin
        cmd.op       = OP_UINT;
        cmd.len_nib  = {1'b0, ucnt};
        cmd.tail     = {uval_al[7:0], uval_al[15:8], uval_al[23:16], uval_al[31:24]};
        cmd.tail_cnt = ucnt;
      end
      KIND_OPAQUE: begin
        cmd.op        = OP_OPAQUE;
        cmd.len_nib   = opt_nibble(item.value_length);
        cmd.tail[1:0] = opt_ext_bytes(item.value_length);
        cmd.tail_cnt  = {1'b0, opt_ext_cnt(item.value_length)};
      end
      KIND_MARKER: begin
        if (item.value_length == '0) begin
          cmd.status = ST_OK;  // empty payload: nothing written
        end else begin
          cmd.op   = OP_MARKER;
          cmd.head = MARKER_BYTE;
        end
      end
      KIND_DATA: begin
        cmd.op   = OP_DATA;
        cmd.head = item.data_byte;
      end
      default: begin
        cmd.status = ST_INVALID;
      end
    endcase
  end

endmodule

// ===== hw/rtl/cms_fifo.sv =====
// Small command queue between front and back; register storage.
// DEPTH must be a power of two. No package dependency.
module cms_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/cms_back.sv =====
// Back end: builds the byte sequence of one command against message state,
// then emits one result beat per cycle via the output register unless stalled.
// Depends on cms_pkg and cms_result_if.
module cms_back (
  input  logic           clk,
  input  logic           rst,
  input  cms_pkg::cmd_t  cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  input  logic [15:0]    capacity,
  cms_result_if.source   result
);
  import cms_pkg::*;

  typedef enum logic {S_BUILD, S_EMIT} state_t;

  state_t          state;
  logic [6:0][7:0] seq;
  logic [2:0]      seq_cnt;
  logic [2:0]      idx;
  logic [1:0]      pend_status;
  logic            post_check;
  logic            commit_opt;
  logic [15:0]     hold_onum;
  logic [15:0]     hold_vlen;
  logic [15:0]     wp;
  logic [15:0]     last_opt;

  // build-time values
  logic [15:0]     delta;
  logic            backward;
  logic [1:0]      dcnt;
  logic [1:0][7:0] dext;
  logic [7:0]      b_head;
  logic [1:0]      b_dcnt;
  logic [6:0][7:0] b_seq;
  logic [2:0]      b_cnt;
  logic [1:0]      b_status;
  logic            b_post;
  logic            b_commit;
  logic            b_hdr_reset;
  logic [2:0]      k;
  logic [2:0]      t;

  // emit-time values
  logic            load_ok;
  logic            emit_go;
  logic            have_byte;
  logic            room;
  logic [15:0]     wp_inc;
  logic            final_byte;
  logic            overflow;

  always_comb begin
    delta    = cmd.opt_num - last_opt;
    backward = cmd.opt_num < last_opt;
    dcnt     = opt_ext_cnt(delta);
    dext     = opt_ext_bytes(delta);

    b_head      = cmd.head;
    b_dcnt      = 2'd0;
    b_status    = ST_OK;
    b_post      = 1'b0;
    b_commit    = 1'b0;
    b_hdr_reset = 1'b0;
    b_cnt       = 3'd1 + cmd.tail_cnt;
    unique case (cmd.op)
      OP_HEADER: begin
        if (capacity < HDR_BYTES + {12'd0, cmd.tok_len}) begin
          b_cnt    = 3'd0;
          b_status = ST_FULL;
        end else begin
          b_hdr_reset = 1'b1;
        end
      end
      OP_UINT, OP_OPAQUE: begin
        if (backward) begin
          b_cnt    = 3'd0;
          b_status = ST_INVALID;
        end else begin
          b_head   = {opt_nibble(delta), cmd.len_nib};
          b_dcnt   = dcnt;
          b_cnt    = 3'd1 + {1'b0, dcnt} + cmd.tail_cnt;
          b_commit = 1'b1;
          b_post   = (cmd.op == OP_OPAQUE);
        end
      end
      OP_MARKER: b_post = 1'b1;
      OP_DATA:   b_post = 1'b0;
      OP_STATUS: begin
        b_cnt    = 3'd0;
        b_status = cmd.status;
      end
      default: b_cnt = 3'd0;
    endcase

    // head, then delta extension, then the tail prepared by the front
    b_seq    = '0;
    b_seq[0] = b_head;
    k        = '0;
    t        = '0;
    for (int i = 1; i < 7; i++) begin
      k = 3'(i - 1);
      t = k - {1'b0, b_dcnt};
      if (k < {1'b0, b_dcnt}) b_seq[i] = dext[k[0]];
      else if (t < 3'd4)      b_seq[i] = cmd.tail[t[1:0]];
      else                    b_seq[i] = '0;
    end
  end

  always_comb begin
    load_ok    = !result.valid || result.ready;
    emit_go    = (state == S_EMIT) && load_ok;
    have_byte  = idx < seq_cnt;
    room       = wp < capacity;
    wp_inc     = wp + 16'd1;
    final_byte = (idx == seq_cnt - 3'd1);
    overflow   = post_check &&
                 (({1'b0, wp_inc} + {1'b0, hold_vlen}) > {1'b0, capacity});
    cmd_pop    = (state == S_BUILD) && cmd_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_BUILD;
      wp           <= '0;
      last_opt     <= '0;
      result.valid <= 1'b0;
    end else begin
      // a new beat loads the register; an unaccepted beat stays
      result.valid <= emit_go || (result.valid && !result.ready);
      unique case (state)
        S_BUILD: begin
          if (cmd_valid) begin
            seq         <= b_seq;
            seq_cnt     <= b_cnt;
            idx         <= '0;
            pend_status <= b_status;
            post_check  <= b_post;
            commit_opt  <= b_commit;
            hold_onum   <= cmd.opt_num;
            hold_vlen   <= cmd.value_length;
            if (b_hdr_reset) begin
              wp       <= '0;
              last_opt <= '0;
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load_ok) begin
            if (have_byte && room) begin
              result.out_byte     <= seq[idx];
              result.byte_valid   <= 1'b1;
              result.status       <= ST_OK;
              result.message_size <= wp_inc;
              result.last         <= final_byte && !overflow;
              wp                  <= wp_inc;
              idx                 <= idx + 3'd1;
              if (final_byte) begin
                if (overflow) begin
                  pend_status <= ST_FULL;  // reserved length does not fit
                end else begin
                  if (commit_opt) last_opt <= hold_onum;
                  state <= S_BUILD;
                end
              end
            end else begin
              // status-only beat: error, full buffer or nothing to write
              result.out_byte     <= '0;
              result.byte_valid   <= 1'b0;
              result.status       <= have_byte ? ST_FULL : pend_status;
              result.message_size <= wp;
              result.last         <= 1'b1;
              state               <= S_BUILD;
            end
          end
        end
        default: state <= S_BUILD;
      endcase
    end
  end

endmodule

// ===== hw/rtl/cms_checker.sv =====
// Port-level checks on the result channel of the CoAP message serializer.
// Bound to coap_message_serializer_core; depends on cms_pkg.
module cms_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  res_byte,
  input logic        res_byte_valid,
  input logic        res_last,
  input logic [1:0]  res_status
);
  import cms_pkg::*;

  // nothing is shown in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a written byte always carries ok status
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_byte_valid) |-> (res_status == ST_OK))
    else $error("byte beat with error status");

  // a status-only beat closes its item and carries a zero byte
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_byte_valid) |-> (res_last && res_byte == '0))
    else $error("status beat not last or nonzero byte");

  // status codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_status == ST_OK || res_status == ST_INVALID ||
                   res_status == ST_FULL))
    else $error("undefined status code");

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_byte) &&
                                   $stable(res_last) && $stable(res_status)))
    else $error("result changed while stalled");

endmodule

bind coap_message_serializer_core cms_checker u_cms_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .res_byte       (result.out_byte),
  .res_byte_valid (result.byte_valid),
  .res_last       (result.last),
  .res_status     (result.status)
);

// ===== verif/cms_stream_checker.sv =====
// Stream checker for the CoAP message serializer: watches item, result and cfg
// channels, predicts every result beat and compares it field by field.
// Depends on cms_pkg and the channel interfaces in cms_if.
module cms_stream_checker (
  input  logic  clk,
  input  logic  rst,
  cms_item_if   item,
  cms_result_if result,
  cms_cfg_if    cfg,
  output int    mismatches,
  output int    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import cms_pkg::*;

  localparam logic [15:0] EXT1_BASE = 16'd13;
  localparam logic [15:0] EXT2_BASE = 16'd269;
  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [1:0]  status;
    logic [15:0] message_size;
  } beat_t;

  beat_t       expected_beats[$];
  beat_t       item_beats[$];
  logic [15:0] capacity;
  logic [15:0] write_pos;
  logic [15:0] option_base;
  int unsigned beats_seen;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("%0t: beat %0d: %s", $time, beats_seen, what);
    mismatches++;
  endtask

  function automatic bit emit_byte(input logic [7:0] b);
    beat_t nb;
    if (write_pos >= capacity) return 1'b0;
    write_pos = write_pos + 16'd1;
    nb = '{out_byte: b, byte_valid: 1'b1, last: 1'b0, status: ST_OK,
           message_size: write_pos};
    item_beats.push_back(nb);
    return 1'b1;
  endfunction

  function automatic logic [3:0] field_nibble(input logic [15:0] v);
    if (v < EXT1_BASE) return v[3:0];
    if (v < EXT2_BASE) return 4'd13;
    return 4'd14;
  endfunction

  function automatic bit emit_extension(input logic [15:0] v);
    logic [15:0] e;
    if (v >= EXT2_BASE) begin
      e = v - EXT2_BASE;
      if (!emit_byte(e[15:8])) return 1'b0;
      return emit_byte(e[7:0]);
    end
    e = v - EXT1_BASE;
    if (v >= EXT1_BASE) return emit_byte(e[7:0]);
    return 1'b1;
  endfunction

  function automatic bit emit_option_header(input logic [15:0] delta,
                                            input logic [15:0] len);
    if (!emit_byte({field_nibble(delta), field_nibble(len)})) return 1'b0;
    if (!emit_extension(delta)) return 1'b0;
    return emit_extension(len);
  endfunction

  // Works out the beats of the item on the channel and queues them.
  function automatic void encode_item();
    logic [1:0]  st;
    bit          ok;
    logic [31:0] v;
    logic [15:0] value_bytes;
    beat_t       sb;
    st = ST_OK;
    ok = 1'b1;
    v = item.option_value;
    item_beats.delete();
    case (item.kind)
      KIND_HEADER: begin
        if (item.tok_len > TKL_MAX) begin
          st = ST_INVALID;
          ok = 1'b0;
        end else if (capacity < HDR_BYTES + 16'(item.tok_len)) begin
          st = ST_FULL;
          ok = 1'b0;
        end else begin
          write_pos = '0;
          option_base = '0;
          void'(emit_byte({COAP_VERSION, item.msg_type, item.tok_len}));
          void'(emit_byte(item.code));
          void'(emit_byte(item.msg_id[15:8]));
          void'(emit_byte(item.msg_id[7:0]));
        end
      end
      KIND_UINT: begin
        if (item.opt_num < option_base) begin
          st = ST_INVALID;
          ok = 1'b0;
        end else begin
          value_bytes = (v[31:24] != 0) ? 16'd4 : (v[31:16] != 0) ? 16'd3 :
                        (v[31:8] != 0) ? 16'd2 : (v != 0) ? 16'd1 : 16'd0;
          ok = emit_option_header(item.opt_num - option_base, value_bytes);
          for (int i = 3; i >= 0; i--)
            if (ok && i < value_bytes) ok = emit_byte(v[8*i +: 8]);
          if (!ok) st = ST_FULL;
          else option_base = item.opt_num;
        end
      end
      KIND_OPAQUE: begin
        if (item.opt_num < option_base) begin
          st = ST_INVALID;
          ok = 1'b0;
        end else begin
          ok = emit_option_header(item.opt_num - option_base, item.value_length);
          if (ok && ({1'b0, write_pos} + {1'b0, item.value_length} > {1'b0, capacity}))
            ok = 1'b0;
          if (!ok) st = ST_FULL;
          else option_base = item.opt_num;
        end
      end
      KIND_MARKER: begin
        // zero payload length: no marker, a lone ok status beat
        if (item.value_length == 16'd0) ok = 1'b0;
        else begin
          ok = emit_byte(MARKER_BYTE);
          if (ok && ({1'b0, write_pos} + {1'b0, item.value_length} > {1'b0, capacity}))
            ok = 1'b0;
          if (!ok) st = ST_FULL;
        end
      end
      KIND_DATA: begin
        ok = emit_byte(item.data_byte);
        if (!ok) st = ST_FULL;
      end
      default: begin
        st = ST_INVALID;
        ok = 1'b0;
      end
    endcase
    if (!ok || item_beats.size() == 0) begin
      sb = '{out_byte: 8'h00, byte_valid: 1'b0, last: 1'b0, status: st,
             message_size: write_pos};
      item_beats.push_back(sb);
    end
    sb = item_beats.pop_back();
    sb.last = 1'b1;
    item_beats.push_back(sb);
    foreach (item_beats[i]) expected_beats.push_back(item_beats[i]);
  endfunction

  always @(posedge clk) begin
    beat_t want;
    if (rst) begin
      capacity = CAP_RESET;
      write_pos = '0;
      option_base = '0;
      expected_beats.delete();
      mismatches = 0;
      beats_seen = 0;
    end else begin
      // results first: a beat can never belong to an item taken at this edge
      if (result.valid && result.ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, byte %02h status %0d",
                                    result.out_byte, result.status));
        end else begin
          want = expected_beats.pop_front();
          if (result.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      result.out_byte, want.out_byte));
          if (result.byte_valid !== want.byte_valid)
            report_mismatch($sformatf("byte_valid %b, expected %b",
                                      result.byte_valid, want.byte_valid));
          if (result.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", result.last, want.last));
          if (result.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result.status, want.status));
          if (result.message_size !== want.message_size)
            report_mismatch($sformatf("message_size %0d, expected %0d",
                                      result.message_size, want.message_size));
        end
        beats_seen++;
      end
      if (cfg.valid && cfg.ready) capacity = cfg.data;
      if (item.valid && item.ready) encode_item();
    end
    outstanding = expected_beats.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the CoAP message serializer testbench: clock, reset, stimulus and verdict.
// Depends on cms_pkg, cms_if, coap_message_serializer_core and cms_stream_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cms_pkg::*;

  // kinds past the last defined one; the block must answer them with invalid
  localparam logic [2:0] KIND_UNUSED_MIN = 3'd5;
  localparam logic [2:0] KIND_UNUSED_MAX = 3'd7;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on any channel
  localparam int DRAIN_CYCLES   = 16;
  localparam int PHASE_ITEMS    = 66;
  localparam int PHASES         = 6;
  // capacity per random phase: the top extreme, tight buffers that fill up
  // inside one message, and roomy ones where messages run to completion
  localparam logic [15:0] PHASE_CAPACITY [PHASES] =
    '{16'hFFFF, 16'd24, 16'd1024, 16'd60, 16'd16, 16'd300};

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] msg_id;
    logic [1:0]  msg_type;
    logic [7:0]  code;
    logic [3:0]  tok_len;
    logic [15:0] opt_num;
    logic [31:0] option_value;
    logic [15:0] value_length;
    logic [7:0]  data_byte;
  } action_t;

  logic clk;
  logic rst;
  int   mismatch_count;
  int   beats_owed;       // expected result beats not yet seen
  int   items_sent = 0;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   stall_cycles = 0;

  cms_item_if   item_ch ();
  cms_result_if result_ch ();
  cms_cfg_if    cfg_ch ();

  coap_message_serializer_core uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  cms_stream_checker stream_check (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatch_count),
    .outstanding (beats_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready drawn fresh every cycle; idle share follows the phase.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Every field random; callers overwrite the ones the kind uses, so the
  // unused fields keep toggling and must be ignored by the block.
  function automatic action_t random_action(input logic [2:0] kind);
    action_t a;
    a.kind         = kind;
    a.msg_id       = 16'($urandom);
    a.msg_type     = 2'($urandom);
    a.code         = 8'($urandom);
    a.tok_len      = 4'($urandom);
    a.opt_num      = 16'($urandom);
    a.option_value = $urandom;
    a.value_length = 16'($urandom);
    a.data_byte    = 8'($urandom);
    return a;
  endfunction

  function automatic action_t option_action(input logic [2:0] kind,
                                            input logic [15:0] onum,
                                            input logic [31:0] oval,
                                            input logic [15:0] vlen);
    action_t a;
    a = random_action(kind);
    a.opt_num      = onum;
    a.option_value = oval;
    a.value_length = vlen;
    return a;
  endfunction

  // Next option number: mostly short deltas, some in the one-byte and
  // two-byte extension ranges, a few huge; clamps at the top of the range.
  function automatic logic [15:0] step_option(input logic [15:0] cur);
    int unsigned pick;
    int unsigned d;
    int unsigned sum;
    pick = $urandom_range(99);
    if (pick < 50) d = $urandom_range(12);
    else if (pick < 80) d = $urandom_range(268, 13);
    else if (pick < 95) d = $urandom_range(1500, 269);
    else d = $urandom_range(65535);
    sum = cur + d;
    return (sum > 65535) ? 16'hFFFF : 16'(sum);
  endfunction

  // Sender: random gaps before the beat, valid kept high across back-to-back
  // items. Ready is looked at on the falling edge, where it is settled.
  task automatic send_action(input action_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.kind         <= a.kind;
    item_ch.msg_id       <= a.msg_id;
    item_ch.msg_type     <= a.msg_type;
    item_ch.code         <= a.code;
    item_ch.tok_len      <= a.tok_len;
    item_ch.opt_num      <= a.opt_num;
    item_ch.option_value <= a.option_value;
    item_ch.value_length <= a.value_length;
    item_ch.data_byte    <= a.data_byte;
    do @(negedge clk); while (!item_ch.ready);
    @(posedge clk);
    items_sent++;
  endtask

  // Sender goes quiet until the last predicted beat has been taken.
  task automatic hold_until_drained();
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (beats_owed != 0);
    @(posedge clk);
  endtask

  // Capacity is only changed with the block idle: drain, let the pipe settle,
  // then one cfg beat.
  task automatic write_capacity(input logic [15:0] cap);
    hold_until_drained();
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cap;
    do @(negedge clk); while (!cfg_ch.ready);
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // One well-formed message: header, token, ascending options (opaque ones
  // followed by some value bytes), optional marker and payload.
  task automatic send_message();
    action_t     a;
    logic [3:0]  tkl;
    logic [15:0] cursor;
    logic [15:0] vlen;
    a = random_action(KIND_HEADER);
    tkl = 4'($urandom_range(8));
    a.tok_len = tkl;
    send_action(a);
    repeat (tkl) send_action(random_action(KIND_DATA));
    cursor = '0;
    repeat ($urandom_range(4)) begin
      cursor = step_option(cursor);
      if ($urandom_range(1) == 0) begin
        vlen = 16'($urandom_range(4));
        send_action(option_action(KIND_UINT, cursor,
                                  (vlen == 0) ? 32'd0 : ($urandom >> (8 * (4 - vlen))),
                                  16'($urandom)));
      end else begin
        vlen = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6));
        send_action(option_action(KIND_OPAQUE, cursor, $urandom, vlen));
        repeat ((vlen > 6) ? 2 : vlen) send_action(random_action(KIND_DATA));
      end
    end
    if ($urandom_range(3) != 0) begin
      vlen = 16'($urandom_range(8, 1));
      send_action(option_action(KIND_MARKER, 16'($urandom), $urandom, vlen));
      repeat (vlen) send_action(random_action(KIND_DATA));
    end
  endtask

  initial begin
    action_t a;
    int      quota;
    int      pick;
    rst = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.kind         = KIND_HEADER;
    item_ch.msg_id       = '0;
    item_ch.msg_type     = '0;
    item_ch.code         = '0;
    item_ch.tok_len      = '0;
    item_ch.opt_num      = '0;
    item_ch.option_value = '0;
    item_ch.value_length = '0;
    item_ch.data_byte    = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = '0;
    send_idle_pct = 16;
    recv_idle_pct = 56;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ---- directed, reset capacity of 1024 ----
    // header with every field at its top value
    a = random_action(KIND_HEADER);
    a.msg_type = 2'd3;
    a.code     = 8'hFF;
    a.msg_id   = 16'hFFFF;
    a.tok_len  = TKL_MAX;
    send_action(a);
    a = random_action(KIND_DATA);
    a.data_byte = 8'h00;
    send_action(a);
    a.data_byte = 8'hFF;
    send_action(a);
    // deltas 0, 12, 13 (one ext byte, low end), 268 (one ext byte, high end),
    // 269 (two ext bytes) and a huge one; values 0 to 4 bytes wide. The
    // 269 delta with a 4-byte value gives the longest beat run, seven.
    send_action(option_action(KIND_UINT, 16'd0,    32'h0,         16'd0));
    send_action(option_action(KIND_UINT, 16'd12,   32'hFF,        16'd0));
    send_action(option_action(KIND_UINT, 16'd25,   32'h100,       16'd0));
    send_action(option_action(KIND_UINT, 16'd293,  32'hFF_FFFF,   16'd0));
    send_action(option_action(KIND_UINT, 16'd562,  32'hFFFF_FFFF, 16'd0));
    send_action(option_action(KIND_UINT, 16'hFFFF, 32'h1,         16'd0));
    // option number going backwards
    send_action(option_action(KIND_UINT, 16'd100, 32'h5, 16'd0));
    // opaque length in the one-byte ext form, then one that cannot fit
    send_action(option_action(KIND_OPAQUE, 16'hFFFF, 32'h0, 16'd13));
    send_action(option_action(KIND_OPAQUE, 16'hFFFF, 32'h0, 16'hFFFF));
    send_action(option_action(KIND_OPAQUE, 16'd0,    32'h0, 16'd1));
    // marker: empty payload writes nothing; fitting; payload too long
    send_action(option_action(KIND_MARKER, 16'd0, 32'h0, 16'd0));
    send_action(option_action(KIND_MARKER, 16'd0, 32'h0, 16'd2));
    send_action(option_action(KIND_MARKER, 16'd0, 32'h0, 16'hFFFF));
    // token length past 8, smallest and largest
    a = random_action(KIND_HEADER);
    a.tok_len = 4'd9;
    send_action(a);
    a.tok_len = 4'hF;
    send_action(a);
    send_action(random_action(KIND_UNUSED_MIN));
    send_action(random_action(KIND_UNUSED_MAX));

    // zero capacity: nothing fits, not even a header
    write_capacity(16'd0);
    a = random_action(KIND_HEADER);
    a.tok_len = 4'd0;
    send_action(a);
    send_action(random_action(KIND_DATA));

    // capacity 6: header plus token one over, then exactly at the limit;
    // the option then stops after two of its three header bytes
    write_capacity(16'd6);
    a.tok_len = 4'd3;
    send_action(a);
    a.tok_len = 4'd2;
    send_action(a);
    send_action(option_action(KIND_UINT, 16'd300, 32'h1234, 16'd0));
    send_action(random_action(KIND_DATA));

    // ---- random phases ----
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(PHASE_CAPACITY[p]);
      if (p == 2) begin
        send_idle_pct = 56;
        recv_idle_pct = 16;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      quota = items_sent + PHASE_ITEMS;
      while (items_sent < quota) begin
        pick = $urandom_range(99);
        if (pick < 60) send_message();
        else if (pick < 95)
          repeat ($urandom_range(3, 1)) send_action(random_action(3'($urandom)));
        else hold_until_drained();
      end
    end

    // ---- wind down ----
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && beats_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
